@@ hw/rtl/matrix_elementary_line_ops_unit_defines.svh @@
// Assertion macros shared by the checker of the matrix line operations unit.
// No dependencies; include by bare file name where assertions are written.
`ifndef MATRIX_ELEMENTARY_LINE_OPS_UNIT_DEFINES_SVH
`define MATRIX_ELEMENTARY_LINE_OPS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MLEO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MLEO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/mleo_pkg.sv @@
// Types and constants of the matrix line operations unit.
// No dependencies; imported by the interfaces, the top level and the checker.
`default_nettype none

package mleo_pkg;

   // Field widths of the request and response words.
   localparam int DATA_W    = 32;
   localparam int IDX_W     = 3;
   localparam int OP_W      = 3;
   localparam int CNT_W     = 4;
   localparam int CSR_IDX_W = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'd1;

   // Reset value of both line counts.
   localparam logic [CNT_W-1:0] COUNT_RESET = 4'd3;

   // Operation codes; among the line operations, odd codes work on columns, even codes on rows.
   typedef enum logic [OP_W-1:0] {
      OP_LOAD      = 3'd0,
      OP_READ      = 3'd1,
      OP_SCALE_ROW = 3'd2,
      OP_SCALE_COL = 3'd3,
      OP_ADD_ROW   = 3'd4,
      OP_ADD_COL   = 3'd5,
      OP_SUB_ROW   = 3'd6,
      OP_SUB_COL   = 3'd7
   } op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_WALK,
      S_FINISH
   } state_type;

endpackage

`default_nettype wire

@@ hw/rtl/mleo_req_if.sv @@
// Request channel: valid/ready handshake carrying one operation word.
// Depends on mleo_pkg for field widths.
`default_nettype none

interface mleo_req_if import mleo_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic [IDX_W-1:0]         target_index;
   logic [IDX_W-1:0]         source_index;
   logic [IDX_W-1:0]         element_row;
   logic [IDX_W-1:0]         element_col;
   logic signed [DATA_W-1:0] scalar;
   logic signed [DATA_W-1:0] load_value;

   modport source (
      output valid, operation, target_index, source_index, element_row,
             element_col, scalar, load_value,
      input  ready
   );

   modport sink (
      input  valid, operation, target_index, source_index, element_row,
             element_col, scalar, load_value,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/mleo_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one result word.
// Depends on mleo_pkg for field widths.
`default_nettype none

interface mleo_rsp_if import mleo_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] read_value;
   logic                     status;

   modport source (
      output valid, read_value, status,
      input  ready
   );

   modport sink (
      input  valid, read_value, status,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/mleo_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mleo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/matrix_elementary_line_ops_unit.sv @@
// Matrix elementary row and column operations unit.
// Holds a square matrix of 32-bit words in RAM and applies one operation per request word:
// load, read, scale a line, or add/subtract a source line into a target line.
// Channels: req_bus (sink) takes a request word when valid and ready are high at a clock
// edge; rsp_bus (source) returns exactly one response word per request. The csr_ port writes
// the row count (index 0) or column count (index 1); write it only while the unit is idle.
// A line operation walks one element per active column for a row operation, one per active
// row for a column operation. The unit takes one request at a time.
// The line walk performs one read-modify-write per cycle through a shared adder/subtractor
// and one 32x32 multiplier, fed by two RAM copies so target and source are read together.
// A finished response sits in an output register; the unit accepts the next request while
// it waits and only stalls its own completion until the receiver takes the word.
// Reset (synchronous, active high) returns the sequencer to idle, drops rsp valid and sets
// both counts to 3. Matrix contents are not cleared; elements must be loaded before use.
`default_nettype none

module matrix_elementary_line_ops_unit import mleo_pkg::*; #(
   parameter int MAX_DIM = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   mleo_req_if.sink                  req_bus,
   mleo_rsp_if.source                rsp_bus,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CNT_W-1:0]     csr_wdata
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   // Clamp a line count to the matrix dimension.
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] count);
      logic [CNT_W-1:0] res;
      if (int'(count) > MAX_DIM) begin
         res = CNT_W'(MAX_DIM);
      end else begin
         res = count;
      end
      return res;
   endfunction

   // Linear RAM address of element (row, col).
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [CNT_W-1:0] row,
                                                   input logic [CNT_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
   endfunction

   // Sequencer and request registers.
   state_type          state_ff, state_in;
   op_type             op_ff;
   logic [IDX_W-1:0]   tgt_ff, src_ff, erow_ff, ecol_ff;
   logic [DATA_W-1:0]  scalar_ff, load_ff;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   rows_ff, cols_ff;
   logic [DATA_W-1:0]  res_value_ff, res_value_in;
   logic               res_err_ff, res_err_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_value_ff;
   logic               rsp_status_ff;

   // Decoded request and RAM signals.
   logic               accept;
   logic               out_free;
   logic [CNT_W-1:0]   nr, nc, line_lim, walk_lim, walk_idx;
   logic               is_col, elem_err, tgt_bad, src_bad;
   logic [DATA_W-1:0]  rd_t, rd_s, new_val;
   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr_t, rd_addr_s, elem_addr;

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Active counts and index checks.
   assign nr       = clamp_count(rows_ff);
   assign nc       = clamp_count(cols_ff);
   // Odd operation codes address columns.
   assign is_col   = op_ff[0];
   assign line_lim = is_col ? nc : nr;
   assign walk_lim = is_col ? nr : nc;
   assign elem_err = ({1'b0, erow_ff} >= nr) || ({1'b0, ecol_ff} >= nc);
   assign tgt_bad  = {1'b0, tgt_ff} >= line_lim;
   assign src_bad  = {1'b0, src_ff} >= line_lim;

   // The walk reads element 0 from decode, then element k+1 while writing element k.
   assign walk_idx  = (state_ff == S_DECODE) ? '0 : k_ff + 1'b1;
   assign elem_addr = cell_addr(CNT_W'(erow_ff), CNT_W'(ecol_ff));

   always_comb begin
      if (state_ff == S_DECODE && op_ff == OP_READ) begin
         rd_addr_t = elem_addr;
      end else if (is_col) begin
         rd_addr_t = cell_addr(walk_idx, CNT_W'(tgt_ff));
      end else begin
         rd_addr_t = cell_addr(CNT_W'(tgt_ff), walk_idx);
      end
   end

   assign rd_addr_s = is_col ? cell_addr(walk_idx, CNT_W'(src_ff))
                             : cell_addr(CNT_W'(src_ff), walk_idx);

   // Shared arithmetic unit: product, sum or difference of the current element.
   always_comb begin
      unique case (op_ff)
         OP_SCALE_ROW, OP_SCALE_COL: new_val = DATA_W'(rd_t * scalar_ff);
         OP_ADD_ROW, OP_ADD_COL:     new_val = rd_t + rd_s;
         OP_SUB_ROW, OP_SUB_COL:     new_val = rd_t - rd_s;
         default:                    new_val = rd_t;
      endcase
   end

   // Two RAM copies written alike, read at the target and the source element.
   mleo_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_tgt (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ((state_ff == S_WALK) ? new_val : load_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_t),
      .rd_data (rd_t)
   );

   mleo_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_src (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ((state_ff == S_WALK) ? new_val : load_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_s),
      .rd_data (rd_s)
   );

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, RAM control and result staging.
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      res_value_in = res_value_ff;
      res_err_in   = res_err_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      wr_addr      = elem_addr;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_value_in = '0;
            res_err_in   = 1'b0;
            k_in         = '0;
            unique case (op_ff)
               OP_LOAD: begin
                  res_err_in = elem_err;
                  wr_en      = !elem_err;
                  state_in   = S_FINISH;
               end
               OP_READ: begin
                  res_err_in = elem_err;
                  rd_en      = !elem_err;
                  state_in   = elem_err ? S_FINISH : S_READ;
               end
               default: begin
                  // Scaling checks the target only; add and subtract check both lines.
                  res_err_in = tgt_bad ||
                     (src_bad && op_ff != OP_SCALE_ROW && op_ff != OP_SCALE_COL);
                  if (res_err_in || walk_lim == '0) begin
                     state_in = S_FINISH;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = S_WALK;
                  end
               end
            endcase
         end
         S_READ: begin
            res_value_in = rd_t;
            state_in     = S_FINISH;
         end
         S_WALK: begin
            wr_en   = 1'b1;
            wr_addr = is_col ? cell_addr(k_ff, CNT_W'(tgt_ff))
                             : cell_addr(CNT_W'(tgt_ff), k_ff);
            if (walk_idx < walk_lim) begin
               rd_en = 1'b1;
               k_in  = walk_idx;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Request and walk registers; payload only, no reset needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= op_type'(req_bus.operation);
         tgt_ff    <= req_bus.target_index;
         src_ff    <= req_bus.source_index;
         erow_ff   <= req_bus.element_row;
         ecol_ff   <= req_bus.element_col;
         scalar_ff <= DATA_W'(req_bus.scalar);
         load_ff   <= DATA_W'(req_bus.load_value);
      end
      k_ff         <= k_in;
      res_value_ff <= res_value_in;
      res_err_ff   <= res_err_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= COUNT_RESET;
         cols_ff <= COUNT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROWS: rows_ff <= csr_wdata;
            CSR_COLS: cols_ff <= csr_wdata;
         endcase
      end
   end

   // Output register: loaded when a result completes, cleared when taken.
   always_comb begin
      if (state_ff == S_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FINISH && out_free) begin
         rsp_value_ff  <= res_value_ff;
         rsp_status_ff <= res_err_ff;
      end
   end

   // Port drive.
   assign req_bus.ready      = (state_ff == S_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_value = signed'(rsp_value_ff);
   assign rsp_bus.status     = rsp_status_ff;

endmodule

`default_nettype wire

@@ hw/rtl/mleo_checker.sv @@
// Port-level checks of the matrix line operations unit, bound to its top level.
// Depends on mleo_pkg and the assertion macros header.
`default_nettype none
`include "matrix_elementary_line_ops_unit_defines.svh"

module mleo_checker import mleo_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [DATA_W-1:0] rsp_read_value,
   input wire logic              rsp_status
);

   // A stalled response word keeps its value.
   `MLEO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value) && $stable(rsp_status), "response word changed while stalled")

   // The unit works on one request at a time.
   `MLEO_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request accepted while busy")

   // No response can complete in the cycle right after an accept.
   `MLEO_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid), "response appeared too early")

   // An error response carries a zero read value.
   `MLEO_ASSERT_NOW(a_err_zero_value, clock, reset, rsp_valid && rsp_status, rsp_read_value == '0, "error response with nonzero value")

endmodule

bind matrix_elementary_line_ops_unit mleo_checker u_mleo_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_read_value (rsp_bus.read_value),
   .rsp_status     (rsp_bus.status)
);

`default_nettype wire

@@ bench/matrix_ops_checker.sv @@
`timescale 1ns / 100ps
// Checker for the matrix line operations unit: watches both channels and the register port.
// Keeps its own copy of the matrix and the line counts; depends on mleo_pkg and the interfaces.
module matrix_ops_checker import mleo_pkg::*; #(
   parameter int DIM = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   mleo_req_if                  req_mon,
   mleo_rsp_if                  rsp_mon,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata,
   output int                   mismatch_count,
   output int                   pending_count
);

   // One response word as the unit should return it.
   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              status;
   } matrix_answer_type;

   logic [DATA_W-1:0] cells [DIM*DIM];
   logic [CNT_W-1:0]  row_count;
   logic [CNT_W-1:0]  col_count;
   matrix_answer_type answer_queue [$];
   int                faults = 0;

   // Applies one operation word to the shadow matrix and returns the answer it gives.
   function automatic matrix_answer_type apply_matrix_op(
      input op_type            op,
      input logic [IDX_W-1:0]  tgt,
      input logic [IDX_W-1:0]  src,
      input logic [IDX_W-1:0]  erow,
      input logic [IDX_W-1:0]  ecol,
      input logic [DATA_W-1:0] scal,
      input logic [DATA_W-1:0] value
   );
      int                nr;
      int                nc;
      int                line_lim;
      int                walk_lim;
      int                a;
      int                b;
      logic              col_op;
      logic              subtract;
      matrix_answer_type ans;
      nr       = (row_count > DIM) ? DIM : int'(row_count);
      nc       = (col_count > DIM) ? DIM : int'(col_count);
      col_op   = op[0];
      line_lim = col_op ? nc : nr;
      walk_lim = col_op ? nr : nc;
      subtract = (op == OP_SUB_ROW) || (op == OP_SUB_COL);
      ans      = '0;
      case (op)
         OP_LOAD, OP_READ: begin
            if (erow >= nr || ecol >= nc) begin
               ans.status = 1'b1;
            end else if (op == OP_LOAD) begin
               cells[erow * DIM + ecol] = value;
            end else begin
               ans.read_value = cells[erow * DIM + ecol];
            end
         end
         OP_SCALE_ROW, OP_SCALE_COL: begin
            if (tgt >= line_lim) begin
               ans.status = 1'b1;
            end else begin
               for (int k = 0; k < walk_lim; k++) begin
                  a = col_op ? k * DIM + tgt : tgt * DIM + k;
                  cells[a] = cells[a] * scal;
               end
            end
         end
         default: begin
            // Add or subtract; a line into itself doubles or clears naturally.
            if (tgt >= line_lim || src >= line_lim) begin
               ans.status = 1'b1;
            end else begin
               for (int k = 0; k < walk_lim; k++) begin
                  a = col_op ? k * DIM + tgt : tgt * DIM + k;
                  b = col_op ? k * DIM + src : src * DIM + k;
                  cells[a] = subtract ? cells[a] - cells[b] : cells[a] + cells[b];
               end
            end
         end
      endcase
      return ans;
   endfunction

   // Track register writes, predict each accepted request and check each accepted response.
   always @(posedge clock) begin : track
      matrix_answer_type got;
      matrix_answer_type want;
      if (reset) begin
         row_count = COUNT_RESET;
         col_count = COUNT_RESET;
         answer_queue.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_ROWS: row_count = csr_wdata;
               CSR_COLS: col_count = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            answer_queue.push_back(apply_matrix_op(op_type'(req_mon.operation),
               req_mon.target_index, req_mon.source_index, req_mon.element_row,
               req_mon.element_col, req_mon.scalar, req_mon.load_value));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.read_value = rsp_mon.read_value;
            got.status     = rsp_mon.status;
            if (answer_queue.size() == 0) begin
               $error("response word with no request waiting: read_value %h, status %b",
                  got.read_value, got.status);
               faults++;
            end else begin
               want = answer_queue.pop_front();
               if (got !== want) begin
                  faults++;
                  if (got.read_value !== want.read_value)
                     $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                  if (got.status !== want.status)
                     $error("status: expected %b, got %b", want.status, got.status);
               end
            end
         end
      end
      pending_count  <= answer_queue.size();
      mismatch_count <= faults;
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Top of the bench for the matrix line operations unit: clock, reset, stimulus and verdict.
// Depends on mleo_pkg, the request and response interfaces, the unit and matrix_ops_checker.
module testbench;
   import mleo_pkg::*;

   localparam int DIM         = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 14;

   // One request word as the stimulus builds it.
   typedef struct packed {
      op_type            op;
      logic [IDX_W-1:0]  tgt;
      logic [IDX_W-1:0]  src;
      logic [IDX_W-1:0]  erow;
      logic [IDX_W-1:0]  ecol;
      logic [DATA_W-1:0] scalar;
      logic [DATA_W-1:0] value;
   } line_op_word_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CNT_W-1:0]     csr_wdata;
   int                   mismatch_count;
   int                   pending_count;
   int                   stall_cycles;
   logic                 steady;
   logic                 squeeze;

   // Line counts as last written, and which elements hold a loaded value.
   logic [CNT_W-1:0]     rows_written;
   logic [CNT_W-1:0]     cols_written;
   bit                   loaded [DIM*DIM];

   mleo_req_if req_bus ();
   mleo_rsp_if rsp_bus ();

   matrix_elementary_line_ops_unit #(
      .MAX_DIM (DIM)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   matrix_ops_checker #(
      .DIM (DIM)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A count above the matrix size acts as the matrix size.
   function automatic int active(input logic [CNT_W-1:0] count);
      return (count > DIM) ? DIM : int'(count);
   endfunction

   function automatic line_op_word_type compose(input op_type op, input int tgt, input int src,
                                                input int erow, input int ecol,
                                                input logic [DATA_W-1:0] scal,
                                                input logic [DATA_W-1:0] value);
      line_op_word_type w;
      w.op     = op;
      w.tgt    = IDX_W'(tgt);
      w.src    = IDX_W'(src);
      w.erow   = IDX_W'(erow);
      w.ecol   = IDX_W'(ecol);
      w.scalar = scal;
      w.value  = value;
      return w;
   endfunction

   // Operands lean on the extremes and on small values so products do not all collapse.
   function automatic logic [DATA_W-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3, 4:    return DATA_W'(int'($urandom_range(0, 8)) - 4);
         default: return $urandom;
      endcase
   endfunction

   // Turns a word that would touch a never loaded element into a load of that element.
   function automatic line_op_word_type keep_loaded(input line_op_word_type w);
      int               nr;
      int               nc;
      int               line_lim;
      int               walk_lim;
      int               a;
      int               b;
      int               hole;
      logic             scale_op;
      line_op_word_type fixed;
      fixed    = w;
      nr       = active(rows_written);
      nc       = active(cols_written);
      line_lim = w.op[0] ? nc : nr;
      walk_lim = w.op[0] ? nr : nc;
      scale_op = (w.op == OP_SCALE_ROW) || (w.op == OP_SCALE_COL);
      hole     = -1;
      if (w.op == OP_READ) begin
         if (w.erow < nr && w.ecol < nc && !loaded[w.erow * DIM + w.ecol])
            fixed.op = OP_LOAD;
      end else if (w.op != OP_LOAD && w.tgt < line_lim && (scale_op || w.src < line_lim)) begin
         for (int k = walk_lim - 1; k >= 0; k--) begin
            a = w.op[0] ? k * DIM + w.tgt : w.tgt * DIM + k;
            b = w.op[0] ? k * DIM + w.src : w.src * DIM + k;
            if (!loaded[a])
               hole = a;
            if (!scale_op && !loaded[b])
               hole = b;
         end
         if (hole >= 0) begin
            fixed.op   = OP_LOAD;
            fixed.erow = IDX_W'(hole / DIM);
            fixed.ecol = IDX_W'(hole % DIM);
         end
      end
      return fixed;
   endfunction

   // Random word: mostly indices inside the active matrix, some anywhere in the field.
   function automatic line_op_word_type shape_word();
      line_op_word_type w;
      int               nr;
      int               nc;
      int               line_lim;
      nr       = active(rows_written);
      nc       = active(cols_written);
      w.op     = op_type'($urandom_range(0, 7));
      w.tgt    = IDX_W'($urandom_range(0, 7));
      w.src    = IDX_W'($urandom_range(0, 7));
      w.erow   = IDX_W'($urandom_range(0, 7));
      w.ecol   = IDX_W'($urandom_range(0, 7));
      w.scalar = pick_operand();
      w.value  = pick_operand();
      if ($urandom_range(0, 99) >= 12 && nr > 0 && nc > 0) begin
         line_lim = w.op[0] ? nc : nr;
         w.tgt    = IDX_W'($urandom_range(0, line_lim - 1));
         w.src    = IDX_W'($urandom_range(0, line_lim - 1));
         w.erow   = IDX_W'($urandom_range(0, nr - 1));
         w.ecol   = IDX_W'($urandom_range(0, nc - 1));
      end
      return keep_loaded(w);
   endfunction

   // Offers one word, with random gaps before it unless the bench is steady, and returns at the edge that takes it.
   task automatic send_word(input line_op_word_type w);
      if (!steady) begin
         while ($urandom_range(0, 99) < 19) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid        <= 1'b1;
      req_bus.operation    <= w.op;
      req_bus.target_index <= w.tgt;
      req_bus.source_index <= w.src;
      req_bus.element_row  <= w.erow;
      req_bus.element_col  <= w.ecol;
      req_bus.scalar       <= w.scalar;
      req_bus.load_value   <= w.value;
      do @(posedge clock); while (!req_bus.ready);
      if (w.op == OP_LOAD && w.erow < active(rows_written) && w.ecol < active(cols_written))
         loaded[w.erow * DIM + w.ecol] = 1'b1;
   endtask

   // Stops offering and waits until every expected response word has come back.
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Writes the row count and then the column count; only called while the unit is idle.
   task automatic set_counts(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_ROWS;
      csr_wdata    <= rows;
      @(posedge clock);
      csr_index    <= CSR_COLS;
      csr_wdata    <= cols;
      @(posedge clock);
      csr_write_en <= 1'b0;
      rows_written = rows;
      cols_written = cols;
   endtask

   // Receiver: random stalls, a steady stretch, and one long hold-off that backs the unit up.
   initial begin : receiver
      bit squeezed;
      squeezed = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !squeezed) begin
            squeezed = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 19);
         end
      end
   end

   // Watchdog: ends the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Stimulus: directed words at the reset counts, then random phases over several counts.
   initial begin : stimulus
      logic [DATA_W-1:0] seed_values [9];
      logic [CNT_W-1:0]  rows;
      logic [CNT_W-1:0]  cols;
      int                words;
      seed_values = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0,
                      32'h1234_5678, 32'hFFFF_FFF9, 32'h0000_0002, 32'h8000_0001};
      reset                <= 1'b1;
      csr_write_en         <= 1'b0;
      csr_index            <= CSR_ROWS;
      csr_wdata            <= '0;
      steady               <= 1'b0;
      squeeze              <= 1'b0;
      req_bus.valid        <= 1'b0;
      req_bus.operation    <= OP_LOAD;
      req_bus.target_index <= '0;
      req_bus.source_index <= '0;
      req_bus.element_row  <= '0;
      req_bus.element_col  <= '0;
      req_bus.scalar       <= '0;
      req_bus.load_value   <= '0;
      rows_written = COUNT_RESET;
      cols_written = COUNT_RESET;
      foreach (loaded[i])
         loaded[i] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Fill the 3 by 3 matrix of the reset counts, mostly with extreme values.
      for (int i = 0; i < 9; i++)
         send_word(compose(OP_LOAD, 0, 0, i / 3, i % 3, 32'h0, seed_values[i]));
      send_word(compose(OP_READ, 0, 0, 1, 1, 32'h0, 32'h0));
      send_word(compose(OP_SCALE_ROW, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0));
      send_word(compose(OP_SCALE_COL, 2, 0, 0, 0, 32'h8000_0000, 32'h0));
      send_word(compose(OP_ADD_ROW, 1, 2, 0, 0, 32'h0, 32'h0));
      send_word(compose(OP_ADD_COL, 0, 1, 0, 0, 32'h0, 32'h0));
      send_word(compose(OP_SUB_ROW, 2, 0, 0, 0, 32'h0, 32'h0));
      send_word(compose(OP_SUB_COL, 1, 2, 0, 0, 32'h0, 32'h0));
      // A line added to itself doubles; subtracted from itself it clears.
      send_word(compose(OP_ADD_ROW, 1, 1, 0, 0, 32'h0, 32'h0));
      send_word(compose(OP_SUB_COL, 0, 0, 0, 0, 32'h0, 32'h0));
      send_word(compose(OP_READ, 0, 0, 2, 2, 32'h0, 32'h0));
      // Out of range indices: nothing changes and the status flags it.
      send_word(compose(OP_LOAD, 0, 0, 3, 0, 32'h0, 32'hDEAD_BEEF));
      send_word(compose(OP_READ, 0, 0, 0, 7, 32'h0, 32'h0));
      send_word(compose(OP_SCALE_ROW, 5, 0, 0, 0, 32'h0000_0003, 32'h0));
      send_word(compose(OP_ADD_COL, 0, 3, 0, 0, 32'h0, 32'h0));
      send_word(compose(OP_SUB_ROW, 7, 0, 0, 0, 32'h0, 32'h0));
      settle();

      // Random phases; counts of zero and above the matrix size are among them.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0, 1: begin rows = 4'd8;  cols = 4'd8;  end
            2:    begin rows = 4'd1;  cols = 4'd8;  end
            3:    begin rows = 4'd8;  cols = 4'd1;  end
            4:    begin rows = 4'd15; cols = 4'd9;  end
            5:    begin rows = 4'd0;  cols = 4'd6;  end
            6:    begin rows = 4'd6;  cols = 4'd0;  end
            7:    begin rows = 4'd2;  cols = 4'd2;  end
            default: begin
               rows = CNT_W'($urandom_range(1, 8));
               cols = CNT_W'($urandom_range(1, 8));
            end
         endcase
         set_counts(rows, cols);
         words = (rows == 0 || cols == 0) ? 20 : 100;
         steady <= (p == 0);
         for (int i = 0; i < words; i++) begin
            if (p == 1 && i == 40)
               squeeze <= 1'b1;
            send_word(shape_word());
         end
         settle();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/mleo_pkg.sv
hw/rtl/mleo_req_if.sv
hw/rtl/mleo_rsp_if.sv
hw/rtl/mleo_ram.sv
hw/rtl/matrix_elementary_line_ops_unit.sv
hw/rtl/mleo_checker.sv
bench/matrix_ops_checker.sv
bench/testbench.sv
